// ===== rtl/polyphase_sinc_resampler_defines.svh =====
// Assertion macros used by the resampler top level.
`ifndef POLYPHASE_SINC_RESAMPLER_DEFINES_SVH
`define POLYPHASE_SINC_RESAMPLER_DEFINES_SVH
`ifndef SYNTHESIS
`define PSR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("resampler assertion failed");
`define PSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("resampler assertion failed");
`else
`define PSR_ASSERT(lbl, prop)
`define PSR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/psr_pkg.sv =====
// Types, constants and helpers shared by the resampler modules.
`default_nettype none
package psr_pkg;

  localparam int unsigned MAX_TAPS_DEF     = 2048;
  localparam int unsigned PHASE_ROWS_DEF   = 128;
  localparam int unsigned MAX_CHANNELS_DEF = 2;

  localparam int unsigned COEF_W      = 24;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned FRAC_BITS   = 24;
  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned RES_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned STEP_W      = 20;
  localparam int unsigned PHASE_W     = STEP_W + 1;
  localparam int unsigned GAIN_W      = 31;
  localparam int unsigned TAPS_W      = 12;
  localparam int unsigned FRAMES_W    = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned SCALE_W     = COEF_W + 2;
  localparam int unsigned PROD_W      = SAMPLE_W + SCALE_W;
  localparam int unsigned DITHER_W    = 24;
  localparam int unsigned TAPS_RESET  = 393;
  localparam int unsigned DRAIN_CYC   = 5;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_FRAME = 2'd1,
    ACT_PAD   = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_STEP       = 3'd0,
    CFG_OUT_STEP      = 3'd1,
    CFG_PHASE_GAIN    = 3'd2,
    CFG_WINDOW_TAPS   = 3'd3,
    CFG_CHANNEL_COUNT = 3'd4,
    CFG_SAMPLE_MODE   = 3'd5,
    CFG_OUTPUT_FRAMES = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_PHASE,
    ST_ROW,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT,
    ST_DIV
  } psr_state_e;

  typedef struct packed {
    logic [1:0]                 action;
    logic [17:0]                coef_address;
    logic signed [COEF_W-1:0]   coef_value;
    logic signed [COEF_W-1:0]   coef_delta;
    logic signed [SAMPLE_W-1:0] sample_first;
    logic signed [SAMPLE_W-1:0] sample_second;
  } psr_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_first;
    logic signed [SAMPLE_W-1:0] out_second;
    logic                       run_last;
    logic                       finished;
  } psr_out_t;

  // Per-lane control from the sequencer.
  typedef struct packed {
    logic tap_valid;
    logic acc_clear;
    logic wr_en;
    logic commit;
    logic dither_clr;
  } psr_lane_ctrl_t;

  // Offset-binary 8-bit samples are centred; 16-bit samples pass unchanged.
  function automatic logic signed [SAMPLE_W-1:0] psr_map_sample(
      input logic [SAMPLE_W-1:0] raw, input logic mode8);
    logic signed [SAMPLE_W-1:0] res;
    if (mode8) begin
      res = $signed({8'h00, raw[7:0]}) - 16'sd128;
    end else begin
      res = $signed(raw);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/psr_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module psr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/psr_lane.sv =====
// One channel lane: tap ring, multiply-accumulate, dither, rounding and saturation.
`default_nettype none
module psr_lane #(
  parameter int unsigned MAX_TAPS = 2048,
  localparam int unsigned RA_W = $clog2(MAX_TAPS)
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  psr_pkg::psr_lane_ctrl_t                    ctrl_i,
  input  logic [RA_W-1:0]                            raddr_i,
  input  logic [RA_W-1:0]                            waddr_i,
  input  logic signed [psr_pkg::SAMPLE_W-1:0]        wdata_i,
  input  logic signed [psr_pkg::SCALE_W-1:0]         scale_i,
  input  logic                                       sample_mode_i,
  output logic signed [psr_pkg::SAMPLE_W-1:0]        result_o
);
  import psr_pkg::*;

  localparam int unsigned ACC_W = PROD_W + $clog2(MAX_TAPS);
  localparam int unsigned S_W   = ACC_W - 6;
  localparam int unsigned T_W   = S_W + 1;

  localparam logic signed [T_W:0] HALF   = (T_W+1)'(32768);
  localparam logic signed [T_W:0] S16MAX = (T_W+1)'(32767);
  localparam logic signed [T_W:0] S16MIN = (T_W+1)'(-32768);
  localparam logic signed [T_W:0] S8MAX  = (T_W+1)'(127);
  localparam logic signed [T_W:0] S8MIN  = (T_W+1)'(-128);
  localparam logic signed [T_W:0] OFS8   = (T_W+1)'(128);

  logic [SAMPLE_W-1:0]        rd_raw;
  logic signed [SAMPLE_W-1:0] samp_a_q, samp_b_q;
  logic [3:0]                 vld_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [DITHER_W-1:0] dither_q;
  logic signed [T_W:0]        t_x, r_x, dith_full;
  logic signed [DITHER_W-1:0] dith_new;

  // Tap ring storage for this channel.
  psr_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.wr_en),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .raddr_i (raddr_i),
    .rdata_o (rd_raw)
  );

  // Valid pipeline that follows each issued tap to the accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], ctrl_i.tap_valid};
    end
  end

  // Sample delay to meet the interpolated coefficient, product and sum.
  always_ff @(posedge clk_i) begin
    samp_a_q <= $signed(rd_raw);
    samp_b_q <= samp_a_q;
    prod_q   <= PROD_W'(samp_b_q) * PROD_W'(scale_i);
    if (ctrl_i.acc_clear) begin
      acc_q <= '0;
    end else if (vld_q[3]) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Error-feedback dither and round half away from zero.
  always_comb begin
    t_x = (T_W+1)'($signed(acc_q[ACC_W-1:6])) + (T_W+1)'(dither_q);
    if (!t_x[T_W]) begin
      r_x = (t_x + HALF) >>> 16;
    end else begin
      r_x = -((-t_x + HALF) >>> 16);
    end
    dith_full = t_x - (r_x <<< 16);
    dith_new  = dith_full[DITHER_W-1:0];
  end

  // Saturation to the selected sample format.
  always_comb begin
    if (sample_mode_i) begin
      if (r_x > S8MAX) begin
        result_o = 16'sd255;
      end else if (r_x < S8MIN) begin
        result_o = 16'sd0;
      end else begin
        result_o = SAMPLE_W'(r_x + OFS8);
      end
    end else begin
      if (r_x > S16MAX) begin
        result_o = 16'sd32767;
      end else if (r_x < S16MIN) begin
        result_o = -16'sd32768;
      end else begin
        result_o = SAMPLE_W'(r_x);
      end
    end
  end

  // Dither error state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dither_q <= '0;
    end else if (ctrl_i.dither_clr) begin
      dither_q <= '0;
    end else if (ctrl_i.commit) begin
      dither_q <= dith_new;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/polyphase_sinc_resampler.sv =====
// Top level of the polyphase windowed-sinc resampler: sequencer, coefficient unit and merge.
//
// Usage. Configuration writes arrive on cfg_valid_i/cfg_index_i/cfg_data_i and are
// always taken (cfg_ready_o is high); write them only while the block is idle.
// Input transactions (in_valid_i, in_stall_o, in_data_i) load a coefficient, deliver a
// sample frame or a zero pad frame. Results leave on out_valid_o/out_stall_i/out_data_o.
// Each result runs the window through one multiply-accumulate per cycle, all channels
// at once in their own lanes, fed through the single coefficient table read port.
// A frame occupies the block until all its results are emitted; when more than 64
// results fall due, the surplus phase is skipped with the remainder unit.
// Coefficient loads and ignored frames leave the block idle.
// Reset, and every window_taps write, start a clearing pass over all MAX_TAPS slots of
// the tap ring, during which in_stall_o stays high.
// The result register lets a new input transaction be taken while the last result
// waits; while out_stall_i is high, a further result waits inside the block.
`default_nettype none
`include "polyphase_sinc_resampler_defines.svh"
module polyphase_sinc_resampler #(
  parameter int unsigned MAX_TAPS     = psr_pkg::MAX_TAPS_DEF,
  parameter int unsigned PHASE_ROWS   = psr_pkg::PHASE_ROWS_DEF,
  parameter int unsigned MAX_CHANNELS = psr_pkg::MAX_CHANNELS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [psr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [psr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  psr_pkg::psr_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output psr_pkg::psr_out_t                 out_data_o
);
  import psr_pkg::*;

  localparam int unsigned RA_W   = $clog2(MAX_TAPS);
  localparam int unsigned CNT_W  = $clog2(MAX_TAPS + 1);
  localparam int unsigned TDEPTH = PHASE_ROWS * MAX_TAPS;
  localparam int unsigned TA_W   = $clog2(TDEPTH);
  localparam int unsigned ROW_W  = $clog2(PHASE_ROWS);
  localparam int unsigned X_W    = STEP_W + GAIN_W;
  localparam int unsigned RF_W   = X_W - FRAC_BITS;
  localparam int unsigned CH_W   = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned DIV_W  = $clog2(STEP_W);
  localparam int unsigned W_RST  = (TAPS_RESET > MAX_TAPS) ? MAX_TAPS : TAPS_RESET;
  localparam int unsigned PF_RST = W_RST / 2 - 1;

  // Configuration registers.
  logic [STEP_W-1:0]   in_step_q, out_step_q;
  logic [GAIN_W-1:0]   gain_q;
  logic [TAPS_W-1:0]   taps_q;
  logic [1:0]          chan_q;
  logic                mode_q;
  logic [FRAMES_W-1:0] oframes_q;

  // Stream state.
  psr_state_e          state_q, state_d;
  logic [PHASE_W-1:0]  phase_q;
  logic [RA_W-1:0]     head_q;
  logic [CNT_W-1:0]    prefill_q;
  logic [FRAMES_W-1:0] fd_q;
  logic [RES_W-1:0]    res_cnt_q;
  logic [RA_W-1:0]     clr_q;
  logic [CNT_W-1:0]    tap_cnt_q;
  logic [RA_W-1:0]     rslot_q;
  logic [TA_W-1:0]     caddr_q;
  logic [2:0]          drain_q;
  logic [X_W-1:0]      x_q;
  logic [FRAC_BITS-1:0] frac_q;
  logic [STEP_W-1:0]   div_num_q, div_rem_q, div_rem_new;
  logic [DIV_W-1:0]    div_cnt_q;

  // Coefficient interpolation pipeline.
  logic [2*COEF_W-1:0]          coef_rd;
  logic signed [COEF_W-1:0]     value_q;
  logic signed [2*COEF_W:0]     prod1_q;
  logic signed [SCALE_W-1:0]    scale_q;

  // Result register.
  logic     out_valid_q;
  psr_out_t out_q, out_d;

  logic [STEP_W-1:0]  is_eff, os_eff;
  logic [PHASE_W-1:0] os21, is21;
  logic [CNT_W-1:0]   w_eff, w_new;
  logic [CH_W-1:0]    nch;
  logic               cfg_wr, restart;
  logic               accept, frame_item, prefill_path, frame_drop, frame_write, run_start;
  logic [CNT_W-1:0]   prefill_inc;
  logic [PHASE_W-1:0] phase_wrapped, phase_next;
  logic [RA_W-1:0]    slot, head_next, rslot_next;
  logic [FRAMES_W-1:0] fd_next;
  logic [RES_W-1:0]   res_next;
  logic               more_cond, skip_cond, last_tap, out_free, emit_go, is_last;
  logic [RF_W-1:0]    row_full;
  logic [ROW_W-1:0]   row_sat;
  logic [FRAC_BITS-1:0] frac_sat;
  logic [ROW_W+CNT_W-1:0] base_full;
  logic [PHASE_W-1:0] rem_sh;
  logic               cram_we;
  logic [TA_W-1:0]    cram_waddr;
  logic [STEP_W-1:0]  d_phase;
  logic [RA_W-1:0]    lane_waddr;
  psr_lane_ctrl_t     lane_ctrl [MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0] lane_wdata [MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0] lane_res [MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0] res_second;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;
  assign restart     = cfg_wr && (cfg_index_i == CFG_WINDOW_TAPS);

  // Effective register values.
  always_comb begin
    is_eff = (in_step_q == '0) ? STEP_W'(1) : in_step_q;
    os_eff = (out_step_q == '0) ? STEP_W'(1) : out_step_q;
    os21   = {1'b0, os_eff};
    is21   = {1'b0, is_eff};
    if (taps_q < TAPS_W'(2)) begin
      w_eff = CNT_W'(2);
    end else if (32'(taps_q) > 32'(MAX_TAPS)) begin
      w_eff = CNT_W'(MAX_TAPS);
    end else begin
      w_eff = CNT_W'(taps_q);
    end
    if (cfg_data_i[TAPS_W-1:0] < TAPS_W'(2)) begin
      w_new = CNT_W'(2);
    end else if (32'(cfg_data_i[TAPS_W-1:0]) > 32'(MAX_TAPS)) begin
      w_new = CNT_W'(MAX_TAPS);
    end else begin
      w_new = CNT_W'(cfg_data_i[TAPS_W-1:0]);
    end
    if (chan_q == 2'd0) begin
      nch = CH_W'(1);
    end else if (chan_q > 2'd2) begin
      nch = (MAX_CHANNELS > 1) ? CH_W'(2) : CH_W'(1);
    end else if (32'(chan_q) > 32'(MAX_CHANNELS)) begin
      nch = CH_W'(MAX_CHANNELS);
    end else begin
      nch = CH_W'(chan_q);
    end
  end

  // Input decode and frame bookkeeping.
  always_comb begin
    accept       = in_valid_i && !in_stall_o;
    frame_item   = accept && ((action_e'(in_data_i.action) == ACT_FRAME) ||
                              (action_e'(in_data_i.action) == ACT_PAD));
    prefill_path = prefill_q < w_eff;
    frame_drop   = !prefill_path && !(fd_q < oframes_q);
    frame_write  = frame_item && !frame_drop;
    prefill_inc  = prefill_q + CNT_W'(1);
    run_start    = frame_write && (!prefill_path || !(prefill_inc < w_eff));
    phase_wrapped = (phase_q >= os21) ? phase_q - os21 : phase_q;
    slot         = prefill_path ? prefill_q[RA_W-1:0] : head_q;
    head_next    = (32'(head_q) + 32'd1 >= 32'(w_eff)) ? '0 : head_q + RA_W'(1);
    rslot_next   = (32'(rslot_q) + 32'd1 >= 32'(w_eff)) ? '0 : rslot_q + RA_W'(1);
    cram_we      = accept && (action_e'(in_data_i.action) == ACT_LOAD) &&
                   (32'(in_data_i.coef_address) < 32'(TDEPTH));
    cram_waddr   = TA_W'(in_data_i.coef_address);
  end

  // Output loop conditions.
  always_comb begin
    more_cond  = (phase_q < os21) && (fd_q < oframes_q) &&
                 (res_cnt_q < RES_W'(MAX_RESULTS));
    skip_cond  = (res_cnt_q == RES_W'(MAX_RESULTS)) && (phase_q < os21) &&
                 (fd_q < oframes_q);
    last_tap   = (32'(tap_cnt_q) + 32'd1 == 32'(w_eff));
    out_free   = !out_valid_q || !out_stall_i;
    emit_go    = (state_q == ST_EMIT) && out_free;
    phase_next = phase_q + is21;
    fd_next    = fd_q + FRAMES_W'(1);
    res_next   = res_cnt_q + RES_W'(1);
    is_last    = !((phase_next < os21) && (fd_next < oframes_q) &&
                   (res_next < RES_W'(MAX_RESULTS)));
    d_phase    = STEP_W'(os21 - phase_q);
  end

  // Row selection with saturation to the last phase row.
  always_comb begin
    row_full = x_q[X_W-1:FRAC_BITS];
    if (row_full > RF_W'(PHASE_ROWS - 1)) begin
      row_sat  = ROW_W'(PHASE_ROWS - 1);
      frac_sat = '0;
    end else begin
      row_sat  = row_full[ROW_W-1:0];
      frac_sat = x_q[FRAC_BITS-1:0];
    end
    base_full = {{CNT_W{1'b0}}, row_sat} * {{ROW_W{1'b0}}, w_eff};
  end

  // One restoring step of the remainder unit.
  always_comb begin
    rem_sh = {div_rem_q, div_num_q[STEP_W-1]};
    if (rem_sh >= is21) begin
      div_rem_new = STEP_W'(rem_sh - is21);
    end else begin
      div_rem_new = rem_sh[STEP_W-1:0];
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == RA_W'(MAX_TAPS - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (run_start) state_d = ST_CHECK;
      ST_CHECK: begin
        if (more_cond) begin
          state_d = ST_PHASE;
        end else if (skip_cond) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PHASE: state_d = ST_ROW;
      ST_ROW:   state_d = ST_MAC;
      ST_MAC:   if (last_tap) state_d = ST_DRAIN;
      ST_DRAIN: if (drain_q == 3'(DRAIN_CYC - 1)) state_d = ST_EMIT;
      ST_EMIT:  if (out_free) state_d = ST_CHECK;
      ST_DIV:   if (div_cnt_q == DIV_W'(STEP_W - 1)) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
    if (restart) begin
      state_d = ST_CLEAR;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign lane_waddr = (state_q == ST_CLEAR) ? clr_q : slot;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_step_q  <= STEP_W'(1);
      out_step_q <= STEP_W'(1);
      gain_q     <= '0;
      taps_q     <= TAPS_W'(TAPS_RESET);
      chan_q     <= 2'd1;
      mode_q     <= 1'b0;
      oframes_q  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_IN_STEP:       in_step_q  <= cfg_data_i[STEP_W-1:0];
        CFG_OUT_STEP:      out_step_q <= cfg_data_i[STEP_W-1:0];
        CFG_PHASE_GAIN:    gain_q     <= cfg_data_i[GAIN_W-1:0];
        CFG_WINDOW_TAPS:   taps_q     <= cfg_data_i[TAPS_W-1:0];
        CFG_CHANNEL_COUNT: chan_q     <= cfg_data_i[1:0];
        CFG_SAMPLE_MODE:   mode_q     <= cfg_data_i[0];
        CFG_OUTPUT_FRAMES: oframes_q  <= cfg_data_i[FRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and stream bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      phase_q   <= '0;
      head_q    <= '0;
      prefill_q <= CNT_W'(PF_RST);
      fd_q      <= '0;
      res_cnt_q <= '0;
      clr_q     <= '0;
      tap_cnt_q <= '0;
      drain_q   <= '0;
      div_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (restart) begin
        phase_q   <= '0;
        head_q    <= '0;
        fd_q      <= '0;
        prefill_q <= (w_new >> 1) - CNT_W'(1);
        clr_q     <= '0;
      end else begin
        unique case (state_q)
          ST_CLEAR: clr_q <= clr_q + RA_W'(1);
          ST_IDLE: begin
            res_cnt_q <= '0;
            if (frame_write) begin
              if (prefill_path) begin
                prefill_q <= prefill_inc;
              end else begin
                phase_q <= phase_wrapped;
                head_q  <= head_next;
              end
            end
          end
          ST_CHECK: div_cnt_q <= '0;
          ST_ROW: tap_cnt_q <= '0;
          ST_MAC: tap_cnt_q <= tap_cnt_q + CNT_W'(1);
          ST_DRAIN: drain_q <= drain_q + 3'd1;
          ST_EMIT: begin
            drain_q <= '0;
            if (out_free) begin
              fd_q      <= fd_next;
              phase_q   <= phase_next;
              res_cnt_q <= res_next;
            end
          end
          ST_DIV: begin
            div_cnt_q <= div_cnt_q + DIV_W'(1);
            if (div_cnt_q == DIV_W'(STEP_W - 1)) begin
              phase_q <= os21 + is21 - PHASE_W'(1) - {1'b0, div_rem_new};
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_CHECK: begin
        div_num_q <= d_phase - STEP_W'(1);
        div_rem_q <= '0;
      end
      ST_PHASE: x_q <= {{GAIN_W{1'b0}}, d_phase} * {{STEP_W{1'b0}}, gain_q};
      ST_ROW: begin
        frac_q  <= frac_sat;
        caddr_q <= base_full[TA_W-1:0];
        rslot_q <= head_q;
      end
      ST_MAC: begin
        caddr_q <= caddr_q + TA_W'(1);
        rslot_q <= rslot_next;
      end
      ST_DIV: begin
        div_rem_q <= div_rem_new;
        div_num_q <= {div_num_q[STEP_W-2:0], 1'b0};
      end
      default: ;
    endcase
  end

  // Shared coefficient table.
  psr_ram #(.WIDTH(2 * COEF_W), .DEPTH(TDEPTH)) u_coef (
    .clk_i   (clk_i),
    .we_i    (cram_we),
    .waddr_i (cram_waddr),
    .wdata_i ({in_data_i.coef_value, in_data_i.coef_delta}),
    .raddr_i (caddr_q),
    .rdata_o (coef_rd)
  );

  // Linear interpolation between phase rows: value plus floored delta times fraction.
  always_ff @(posedge clk_i) begin
    value_q <= $signed(coef_rd[2*COEF_W-1:COEF_W]);
    prod1_q <= (2*COEF_W+1)'($signed(coef_rd[COEF_W-1:0])) *
               $signed({{COEF_W{1'b0}}, 1'b0, frac_q});
    scale_q <= SCALE_W'(value_q) + SCALE_W'($signed(prod1_q[2*COEF_W:FRAC_BITS]));
  end

  // Channel lanes.
  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
    always_comb begin
      lane_ctrl[c].tap_valid  = (state_q == ST_MAC);
      lane_ctrl[c].acc_clear  = (state_q == ST_ROW);
      lane_ctrl[c].wr_en      = (state_q == ST_CLEAR) ||
                                (frame_write && (32'(c) < 32'(nch)));
      lane_ctrl[c].commit     = emit_go && (32'(c) < 32'(nch));
      lane_ctrl[c].dither_clr = restart;
      if ((state_q == ST_CLEAR) || (action_e'(in_data_i.action) != ACT_FRAME)) begin
        lane_wdata[c] = '0;
      end else if (c == 0) begin
        lane_wdata[c] = psr_map_sample(in_data_i.sample_first, mode_q);
      end else if (c == 1) begin
        lane_wdata[c] = psr_map_sample(in_data_i.sample_second, mode_q);
      end else begin
        lane_wdata[c] = '0;
      end
    end

    psr_lane #(.MAX_TAPS(MAX_TAPS)) u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (lane_ctrl[c]),
      .raddr_i       (rslot_q),
      .waddr_i       (lane_waddr),
      .wdata_i       (lane_wdata[c]),
      .scale_i       (scale_q),
      .sample_mode_i (mode_q),
      .result_o      (lane_res[c])
    );
  end

  if (MAX_CHANNELS > 1) begin : g_second
    assign res_second = lane_res[1];
  end else begin : g_mono
    assign res_second = '0;
  end

  // Merge the lane results into one result transaction.
  always_comb begin
    out_d.out_first  = lane_res[0];
    out_d.out_second = (nch > CH_W'(1)) ? res_second : '0;
    out_d.run_last   = is_last;
    out_d.finished   = (fd_next == oframes_q);
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks on the sequencer and the result register.
  `PSR_ASSERT(a_finished_is_last, (out_valid_q && out_q.finished) |-> out_q.run_last)
  `PSR_ASSERT(a_skip_after_full_run, (state_q == ST_DIV) |-> (res_cnt_q == RES_W'(MAX_RESULTS)))
  `PSR_ASSERT_NEXT(a_emit_waits, (state_q == ST_EMIT) && out_valid_q && out_stall_i, state_q == ST_EMIT)

endmodule
`default_nettype wire
